// File: sv/pipeo_pkg.sv
// ----------------------------------------------------------------------------
// pipeo_pkg
// shared types and constants of the even-odd point-in-polygon block
// ----------------------------------------------------------------------------
package pipeo_pkg;

   localparam int COORD_BITS  = 24;
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS   = 2 * DIFF_BITS;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] vertex_x;
      logic signed [COORD_BITS-1:0] vertex_y;
      logic                         first_vertex;
      logic                         last_vertex;
   } req_beat_type;

   typedef struct packed {
      logic inside_res;
      logic too_few_vertices;
   } rsp_beat_type;

   // operands of one edge test: straddle flag, direction and the four differences
   typedef struct packed {
      logic                        straddle;
      logic                        dy_pos;
      logic signed [DIFF_BITS-1:0] dpx;
      logic signed [DIFF_BITS-1:0] dy;
      logic signed [DIFF_BITS-1:0] dbx;
      logic signed [DIFF_BITS-1:0] dpy;
   } edge_op_type;

   typedef struct packed {
      logic        first;
      logic        last;
      logic        too_few;
      edge_op_type walk_edge;
      edge_op_type close_edge;
   } job_type;

endpackage

// File: sv/point_in_polygon_even_odd_top.sv
// ----------------------------------------------------------------------------
// point_in_polygon_even_odd_top
// even-odd ray-crossing test of a point against a polygon streamed by vertex
// ----------------------------------------------------------------------------
//   channel | ports                       | beat
//   --------+-----------------------------+------------------------------------
//   request | req_valid req_ready req_beat| point, one vertex, first/last marks
//   result  | rsp_valid rsp_ready rsp_beat| inside_res, too_few_vertices
//
// one vertex beat per cycle sustained while the job queue has room; the front
// computes edge differences, the back multiplies (four products) in one stage
// and compares in the next; rsp_valid rises once the last-vertex beat has
// passed through the job queue, the product stage and the result register
// synchronous active-high reset clears polygon state, parity and all valids
// a four-deep job queue lets the front keep taking beats while the result
// register waits on rsp_ready; req_ready drops only when the queue is full
// ----------------------------------------------------------------------------
module point_in_polygon_even_odd_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pipeo_pkg::req_beat_type req_beat,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output pipeo_pkg::rsp_beat_type rsp_beat
);
   import pipeo_pkg::*;

   // front to queue
   job_type push_job;
   logic    push;
   logic    push_ready;

   // queue to back
   job_type pop_job;
   logic    pop;
   logic    pop_valid;

   // front: polygon state and edge operands
   pipeo_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_beat    (req_beat),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .job         (push_job),
      .job_push    (push),
      .queue_ready (push_ready)
   );

   // decoupling queue
   pipeo_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_job),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_data   (pop_job),
      .pop_valid  (pop_valid)
   );

   // back: products, exact compare, parity and result register
   pipeo_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (pop_job),
      .job_valid (pop_valid),
      .job_pop   (pop),
      .rsp_beat  (rsp_beat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

endmodule

// File: sv/pipeo_front.sv
// ----------------------------------------------------------------------------
// pipeo_front
// takes vertex beats, keeps polygon state and builds edge-test jobs
// ----------------------------------------------------------------------------
module pipeo_front (
   input  logic                    clock,
   input  logic                    reset,
   input  pipeo_pkg::req_beat_type req_beat,
   input  logic                    req_valid,
   output logic                    req_ready,
   output pipeo_pkg::job_type      job,
   output logic                    job_push,
   input  logic                    queue_ready
);
   import pipeo_pkg::*;

   logic signed [COORD_BITS-1:0] first_vx_ff, first_vx_in;
   logic signed [COORD_BITS-1:0] first_vy_ff, first_vy_in;
   logic signed [COORD_BITS-1:0] prev_vx_ff, prev_vx_in;
   logic signed [COORD_BITS-1:0] prev_vy_ff, prev_vy_in;
   logic signed [COORD_BITS-1:0] held_px_ff, held_px_in;
   logic signed [COORD_BITS-1:0] held_py_ff, held_py_in;
   logic [1:0]                   tally_ff, tally_in;
   logic                         accept;
   edge_op_type                  walk_op;
   edge_op_type                  close_op;

   function automatic edge_op_type make_edge(
      input logic signed [COORD_BITS-1:0] ax,
      input logic signed [COORD_BITS-1:0] ay,
      input logic signed [COORD_BITS-1:0] bx,
      input logic signed [COORD_BITS-1:0] by,
      input logic signed [COORD_BITS-1:0] px,
      input logic signed [COORD_BITS-1:0] py
   );
      edge_op_type op;
      op.straddle = (ay > py) != (by > py);
      op.dpx      = DIFF_BITS'(px) - DIFF_BITS'(ax);
      op.dy       = DIFF_BITS'(by) - DIFF_BITS'(ay);
      op.dbx      = DIFF_BITS'(bx) - DIFF_BITS'(ax);
      op.dpy      = DIFF_BITS'(py) - DIFF_BITS'(ay);
      op.dy_pos   = !op.dy[DIFF_BITS-1];
      return op;
   endfunction

   assign accept    = req_valid && queue_ready;
   assign req_ready = queue_ready;
   assign job_push  = accept;

   always_comb begin
      if (req_beat.first_vertex) begin
         held_px_in  = req_beat.point_x;
         held_py_in  = req_beat.point_y;
         first_vx_in = req_beat.vertex_x;
         first_vy_in = req_beat.vertex_y;
         tally_in    = 2'd1;
      end else begin
         held_px_in  = held_px_ff;
         held_py_in  = held_py_ff;
         first_vx_in = first_vx_ff;
         first_vy_in = first_vy_ff;
         tally_in    = (tally_ff == 2'd3) ? 2'd3 : tally_ff + 2'd1;
      end
      prev_vx_in = req_beat.vertex_x;
      prev_vy_in = req_beat.vertex_y;
   end

   always_comb begin
      walk_op  = make_edge(prev_vx_ff, prev_vy_ff, req_beat.vertex_x, req_beat.vertex_y,
                           held_px_in, held_py_in);
      // no edge into the first vertex of a polygon
      walk_op.straddle = walk_op.straddle && !req_beat.first_vertex;
      close_op = make_edge(req_beat.vertex_x, req_beat.vertex_y, first_vx_in, first_vy_in,
                           held_px_in, held_py_in);
      job.first      = req_beat.first_vertex;
      job.last       = req_beat.last_vertex;
      job.too_few    = (tally_in != 2'd3);
      job.walk_edge  = walk_op;
      job.close_edge = close_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_vx_ff <= '0;
         first_vy_ff <= '0;
         prev_vx_ff  <= '0;
         prev_vy_ff  <= '0;
         held_px_ff  <= '0;
         held_py_ff  <= '0;
         tally_ff    <= 2'd0;
      end else if (accept) begin
         first_vx_ff <= first_vx_in;
         first_vy_ff <= first_vy_in;
         prev_vx_ff  <= prev_vx_in;
         prev_vy_ff  <= prev_vy_in;
         held_px_ff  <= held_px_in;
         held_py_ff  <= held_py_in;
         tally_ff    <= tally_in;
      end
   end

endmodule

// File: sv/pipeo_queue.sv
// ----------------------------------------------------------------------------
// pipeo_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module pipeo_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pipeo_pkg::job_type push_data,
   output logic               push_ready,
   input  logic               pop,
   output pipeo_pkg::job_type pop_data,
   output logic               pop_valid
);
   import pipeo_pkg::*;

   job_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;

   assign push_ready = (count_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/pipeo_back.sv
// ----------------------------------------------------------------------------
// pipeo_back
// multiplies, compares, tracks parity and holds the result register
// ----------------------------------------------------------------------------
module pipeo_back (
   input  logic                    clock,
   input  logic                    reset,
   input  pipeo_pkg::job_type      job,
   input  logic                    job_valid,
   output logic                    job_pop,
   output pipeo_pkg::rsp_beat_type rsp_beat,
   output logic                    rsp_valid,
   input  logic                    rsp_ready
);
   import pipeo_pkg::*;

   // product stage
   logic                        m_valid_ff, m_valid_in;
   logic                        m_first_ff, m_last_ff, m_too_few_ff;
   logic                        w_straddle_ff, w_dy_pos_ff;
   logic                        c_straddle_ff, c_dy_pos_ff;
   logic signed [PROD_BITS-1:0] w_left_ff, w_right_ff;
   logic signed [PROD_BITS-1:0] c_left_ff, c_right_ff;
   logic signed [PROD_BITS-1:0] w_left_in, w_right_in;
   logic signed [PROD_BITS-1:0] c_left_in, c_right_in;

   logic                        parity_ff, parity_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_beat_type                rsp_beat_ff, rsp_beat_in;

   logic out_free, m_advance, m_load;
   logic walk_cross, close_cross, final_parity;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign m_advance = m_valid_ff && (!m_last_ff || out_free);
   assign m_load    = job_valid && (!m_valid_ff || m_advance);
   assign job_pop   = m_load;

   assign w_left_in  = job.walk_edge.dpx * job.walk_edge.dy;
   assign w_right_in = job.walk_edge.dbx * job.walk_edge.dpy;
   assign c_left_in  = job.close_edge.dpx * job.close_edge.dy;
   assign c_right_in = job.close_edge.dbx * job.close_edge.dpy;

   // crossing when px - ax lies left of the intercept, direction set by sign of dy
   always_comb begin
      walk_cross   = w_straddle_ff &&
                     (w_dy_pos_ff ? (w_left_ff < w_right_ff) : (w_left_ff > w_right_ff));
      close_cross  = c_straddle_ff &&
                     (c_dy_pos_ff ? (c_left_ff < c_right_ff) : (c_left_ff > c_right_ff));
      parity_in    = (m_first_ff ? 1'b0 : parity_ff) ^ walk_cross;
      final_parity = parity_in ^ close_cross;
      rsp_beat_in.inside_res       = final_parity && !m_too_few_ff;
      rsp_beat_in.too_few_vertices = m_too_few_ff;
   end

   always_comb begin
      m_valid_in = m_load ? 1'b1 : (m_advance ? 1'b0 : m_valid_ff);
      if (m_advance && m_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (m_load) begin
         m_first_ff    <= job.first;
         m_last_ff     <= job.last;
         m_too_few_ff  <= job.too_few;
         w_straddle_ff <= job.walk_edge.straddle;
         w_dy_pos_ff   <= job.walk_edge.dy_pos;
         c_straddle_ff <= job.close_edge.straddle;
         c_dy_pos_ff   <= job.close_edge.dy_pos;
         w_left_ff     <= w_left_in;
         w_right_ff    <= w_right_in;
         c_left_ff     <= c_left_in;
         c_right_ff    <= c_right_in;
      end
      if (m_advance && m_last_ff) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         parity_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         m_valid_ff   <= m_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (m_advance) begin
            parity_ff <= parity_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule

// File: sv/pipeo_checker.sv
// ----------------------------------------------------------------------------
// pipeo_checker
// port-level checks of the point-in-polygon block, bound to the top level
// ----------------------------------------------------------------------------
module pipeo_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input pipeo_pkg::req_beat_type req_beat,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input pipeo_pkg::rsp_beat_type rsp_beat
);
   import pipeo_pkg::*;

   // last-vertex beats taken whose result has not yet been delivered
   logic [3:0] pending_ff, pending_in;
   logic       last_taken, rsp_taken;

   assign last_taken = req_valid && req_ready && req_beat.last_vertex;
   assign rsp_taken  = rsp_valid && rsp_ready;
   assign pending_in = pending_ff + 4'(last_taken) - 4'(rsp_taken);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_beat))
      else $error("result beat changed while stalled");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("result beat without a pending last vertex");

   a_small_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat.too_few_vertices |-> !rsp_beat.inside_res)
      else $error("degenerate polygon reported inside");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind point_in_polygon_even_odd_top pipeo_checker u_pipeo_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_beat  (req_beat),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_beat  (rsp_beat)
);

// File: sim/point_in_polygon_even_odd_top_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_even_odd_top_test
// self-checking bench for the streamed even-odd point-in-polygon block
//
// polygons go in one vertex beat at a time; a behavioral model of the
// crossing-number rule runs beside the block and predicts the verdict of every
// closing vertex; the verdict stream is compared field by field in order
// a short table of hand-picked polygons comes first, then random polygons
// (tight, medium, full-range and corner-heavy coordinates), broken sequences
// and loose noise beats, with random gaps on both channels, one long result
// hold-off that backs the block up, and drain pauses on the sender side
// ----------------------------------------------------------------------------
module point_in_polygon_even_odd_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   import pipeo_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 9;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int BEAT_TARGET   = 400;
   localparam int MID_DRAIN_AT  = 200;
   localparam int LONG_HOLD     = 400;
   localparam int HOLD_AFTER    = 15;
   localparam int TAIL_CYCLES   = 20;
   localparam int PRINT_CAP     = 40;
   localparam int COORD_MAX     = (1 <<< (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN     = -(1 <<< (COORD_BITS - 1));

   // how far random coordinates spread around the origin
   typedef enum int {
      SPREAD_TIGHT,
      SPREAD_MID,
      SPREAD_FULL,
      SPREAD_EXTREME
   } spread_type;

   // one row of the directed table; a typed verdict overrides the model
   typedef struct {
      req_beat_type beat;
      bit           typed;
      rsp_beat_type verdict;
   } stim_row_type;

   // ---------------------------------------------------------------------
   // clock, reset and the block
   // ---------------------------------------------------------------------
   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_beat_type req_beat  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_beat_type rsp_beat;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   point_in_polygon_even_odd_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

   // ---------------------------------------------------------------------
   // bookkeeping
   // ---------------------------------------------------------------------
   rsp_beat_type expected_verdicts[$];
   stim_row_type directed_rows[$];
   int           cycle_count    = 0;
   int           mismatch_count = 0;
   int           beats_sent     = 0;
   int           polygons_sent  = 0;
   int           verdicts_seen  = 0;
   int           inside_count   = 0;
   int           too_few_count  = 0;
   bit           long_hold_done = 1'b0;

   // ---------------------------------------------------------------------
   // polygon model state: query point, opening vertex, trailing vertex,
   // running parity and a vertex count that saturates at three
   // ---------------------------------------------------------------------
   longint query_x, query_y;
   longint start_x, start_y;
   longint trail_x, trail_y;
   bit     crossing_parity;
   int     seen_count;

   // exact ray test: the edge straddles the point's y and the ray toward +x
   // meets it; the divide is multiplied out, so the compare flips with dy
   function automatic bit ray_hits_edge(longint ax, longint ay, longint bx, longint by,
                                        longint px, longint py);
      longint dy, lhs, rhs;
      if ((ay > py) == (by > py))
         return 1'b0;
      dy  = by - ay;
      lhs = (px - ax) * dy;
      rhs = (bx - ax) * (py - ay);
      return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
   endfunction

   // advance the model by one vertex beat; a closing vertex yields a verdict
   function automatic void step_polygon(input req_beat_type b, output bit has_verdict,
                                        output rsp_beat_type verdict);
      longint vx, vy;
      bit     closed_parity;
      vx = longint'($signed(b.vertex_x));
      vy = longint'($signed(b.vertex_y));
      if (b.first_vertex) begin
         query_x         = longint'($signed(b.point_x));
         query_y         = longint'($signed(b.point_y));
         start_x         = vx;
         start_y         = vy;
         crossing_parity = 1'b0;
         seen_count      = 1;
      end else begin
         crossing_parity ^= ray_hits_edge(trail_x, trail_y, vx, vy, query_x, query_y);
         if (seen_count < 3)
            seen_count++;
      end
      trail_x = vx;
      trail_y = vy;
      // the closing edge only feeds this verdict, never the running parity
      closed_parity = crossing_parity ^ ray_hits_edge(vx, vy, start_x, start_y,
                                                      query_x, query_y);
      has_verdict                = b.last_vertex;
      verdict.too_few_vertices   = (seen_count < 3);
      verdict.inside_res         = (seen_count >= 3) && closed_parity;
   endfunction

   function automatic stim_row_type row(int px, int py, int vx, int vy, bit first, bit last,
                                        bit typed = 1'b0, bit inside_flag = 1'b0,
                                        bit too_few = 1'b0);
      stim_row_type r;
      r.beat.point_x                = px[COORD_BITS-1:0];
      r.beat.point_y                = py[COORD_BITS-1:0];
      r.beat.vertex_x               = vx[COORD_BITS-1:0];
      r.beat.vertex_y               = vy[COORD_BITS-1:0];
      r.beat.first_vertex           = first;
      r.beat.last_vertex            = last;
      r.typed                       = typed;
      r.verdict.inside_res          = inside_flag;
      r.verdict.too_few_vertices    = too_few;
      return r;
   endfunction

   function automatic logic [COORD_BITS-1:0] pick_coord(spread_type spread);
      int unsigned raw;
      int          value;
      raw = $urandom;
      case (spread)
         SPREAD_TIGHT: value = int'($urandom_range(0, 128)) - 64;
         SPREAD_MID:   value = int'($urandom_range(0, 8192)) - 4096;
         SPREAD_FULL:  value = int'(raw);
         default: begin
            case (raw % 4)
               0:       value = COORD_MIN;
               1:       value = COORD_MAX;
               2:       value = 0;
               default: value = int'($urandom);
            endcase
         end
      endcase
      return value[COORD_BITS-1:0];
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < PRINT_CAP)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // request side: random gap, then hold the beat until it is taken; valid
   // stays up across back-to-back beats so it never gets two updates a step
   // ---------------------------------------------------------------------
   task automatic send_beat(req_beat_type b, bit typed, rsp_beat_type typed_verdict);
      int           gap;
      bit           has_verdict;
      rsp_beat_type verdict;
      // every third stretch of 40 beats runs with no gaps at all
      gap = (((beats_sent / 40) % 3) == 2) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat  <= b;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      step_polygon(b, has_verdict, verdict);
      if (has_verdict)
         expected_verdicts.insert(expected_verdicts.size(),
                                  typed ? typed_verdict : verdict);
   endtask

   // sender pause: nothing offered until every verdict has come back
   task automatic drain_verdicts();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_verdicts.size() != 0);
   endtask

   task automatic send_random_polygon();
      spread_type             spread;
      int                     n_vert;
      logic [COORD_BITS-1:0]  qx, qy;
      bit                     drop_first, drop_last;
      req_beat_type           b;
      spread = spread_type'($urandom_range(0, 3));
      // mostly real polygons, now and then one or two vertices only
      n_vert = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      qx     = pick_coord(spread);
      qy     = pick_coord(spread);
      // broken sequences: a polygon that continues the last one, or that
      // never closes and is cut off by the next opening vertex
      drop_first = ($urandom_range(0, 11) == 0);
      drop_last  = ($urandom_range(0, 11) == 0);
      for (int i = 0; i < n_vert; i++) begin
         // point fields on later vertices are junk the block must ignore
         b.point_x      = (i == 0) ? qx : pick_coord(SPREAD_FULL);
         b.point_y      = (i == 0) ? qy : pick_coord(SPREAD_FULL);
         b.vertex_x     = pick_coord(spread);
         b.vertex_y     = pick_coord(spread);
         b.first_vertex = (i == 0) && !drop_first;
         b.last_vertex  = (i == n_vert - 1) && !drop_last;
         send_beat(b, 1'b0, '0);
      end
      polygons_sent++;
   endtask

   // ---------------------------------------------------------------------
   // run limit
   // ---------------------------------------------------------------------
   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------------
   // result side: random ready gaps, one long hold-off to fill the job
   // queue and stall the request side, then compare against the oldest
   // prediction
   // ---------------------------------------------------------------------
   initial begin : result_side
      int           gap;
      rsp_beat_type want;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (!long_hold_done && verdicts_seen >= HOLD_AFTER) begin
            gap            = LONG_HOLD;
            long_hold_done = 1'b1;
         end else begin
            gap = (((verdicts_seen / 10) % 3) == 1) ? 0 : $urandom_range(0, 8);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         verdicts_seen++;
         inside_count  += rsp_beat.inside_res;
         too_few_count += rsp_beat.too_few_vertices;
         if (expected_verdicts.size() == 0) begin
            report_mismatch($sformatf("verdict %0d arrived with nothing expected",
                                      verdicts_seen));
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_beat.inside_res !== want.inside_res)
               report_mismatch($sformatf("verdict %0d inside_res got %b expected %b",
                                         verdicts_seen, rsp_beat.inside_res,
                                         want.inside_res));
            if (rsp_beat.too_few_vertices !== want.too_few_vertices)
               report_mismatch($sformatf("verdict %0d too_few_vertices got %b expected %b",
                                         verdicts_seen, rsp_beat.too_few_vertices,
                                         want.too_few_vertices));
         end
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin : request_side
      req_beat_type b;
      bit           mid_drain_done;
      mid_drain_done = 1'b0;

      // model starts from the cleared state, same as the block after reset
      query_x = 0; query_y = 0;
      start_x = 0; start_y = 0;
      trail_x = 0; trail_y = 0;
      crossing_parity = 1'b0;
      seen_count      = 0;

      directed_rows = {
         // lone closing vertex straight after reset: too few vertices
         row(0, 0, 0, 0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1),
         // one-vertex polygon, opening and closing at once, extreme fields
         row(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1),
         // two-vertex polygon
         row(80, 80, 0, 0, 1'b1, 1'b0),
         row(0, 0, 16, 16, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1),
         // full-range square around the origin, point at its center
         row(0, 0, COORD_MIN, COORD_MIN, 1'b1, 1'b0),
         row(-1, -1, COORD_MAX, COORD_MIN, 1'b0, 1'b0),
         row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0),
         row(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0),
         // same square, point sitting on the most negative corner
         row(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b0),
         row(0, 0, COORD_MAX, COORD_MIN, 1'b0, 1'b0),
         row(0, 0, COORD_MAX, COORD_MAX, 1'b0, 1'b0),
         row(0, 0, COORD_MIN, COORD_MAX, 1'b0, 1'b1),
         // small square, point on the horizontal bottom edge
         row(80, 0, 0, 0, 1'b1, 1'b0),
         row(0, 0, 160, 0, 1'b0, 1'b0),
         row(0, 0, 160, 160, 1'b0, 1'b0),
         row(0, 0, 0, 160, 1'b0, 1'b1),
         // triangle with a vertex exactly on the ray
         row(16, 16, 0, 0, 1'b1, 1'b0),
         row(0, 0, 32, 16, 1'b0, 1'b0),
         row(0, 0, 0, 32, 1'b0, 1'b1),
         // more vertices after a close with no new opening: polygon grows
         row(0, 0, -32, 16, 1'b0, 1'b0),
         row(0, 0, -16, 48, 1'b0, 1'b1),
         row(7, 7, 8, -8, 1'b0, 1'b1)
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k])
         send_beat(directed_rows[k].beat, directed_rows[k].typed,
                   directed_rows[k].verdict);
      drain_verdicts();

      // random part: mostly well-formed polygons, some loose noise beats
      while (beats_sent < BEAT_TARGET) begin
         if (!mid_drain_done && beats_sent >= MID_DRAIN_AT) begin
            drain_verdicts();
            mid_drain_done = 1'b1;
         end
         if ($urandom_range(0, 6) == 0) begin
            b.point_x      = pick_coord(SPREAD_FULL);
            b.point_y      = pick_coord(SPREAD_FULL);
            b.vertex_x     = pick_coord(SPREAD_FULL);
            b.vertex_y     = pick_coord(SPREAD_FULL);
            b.first_vertex = 1'($urandom_range(0, 1));
            b.last_vertex  = 1'($urandom_range(0, 1));
            send_beat(b, 1'b0, '0);
         end else begin
            send_random_polygon();
         end
      end

      // wind down: everything back, then an idle tail for strays
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_verdicts.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("ran %0d vertex beats (%0d random polygons) and checked %0d verdicts",
               beats_sent, polygons_sent, verdicts_seen);
      $display("verdicts: %0d inside, %0d flagged with too few vertices",
               inside_count, too_few_count);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: filelist.f
sv/pipeo_pkg.sv
sv/pipeo_front.sv
sv/pipeo_queue.sv
sv/pipeo_back.sv
sv/point_in_polygon_even_odd_top.sv
sv/pipeo_checker.sv
sim/point_in_polygon_even_odd_top_test.sv
